[sv/lzo_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// lzo_pkg - shared types and constants of the LZO1X stream decompressor
// Payload structs, parser state encoding and the saturating length adder.
// ============================================================================
package lzo_pkg;

    localparam int WINDOW_BYTES = 65536;
    localparam int LENGTH_BITS  = 32;
    localparam int ADDR_BITS    = $clog2(WINDOW_BYTES);
    localparam int DIST_BITS    = 17;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

    localparam logic [DIST_BITS-1:0] M2_FAR_BASE = 17'h00801;
    localparam logic [DIST_BITS-1:0] M4_BASE     = 17'h04000;
    localparam logic [7:0]           FIRST_LIT_BIAS = 8'd17;
    localparam logic [9:0]           ZERO_RUN_STEP  = 10'd255;
    localparam logic [7:0]           M3_BASE_LEN    = 8'd31;
    localparam logic [7:0]           M4_BASE_LEN    = 8'd7;

    localparam logic OP_BYTE  = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_LENGTH   = 2'd1;
    localparam logic [1:0] ST_OFFSET   = 2'd2;
    localparam logic [1:0] ST_PENDING  = 2'd3;

    typedef enum logic [3:0] {
        PS_FIRST    = 4'd0,
        PS_INSTR    = 4'd1,
        PS_MATCH    = 4'd2,
        PS_LIT      = 4'd3,
        PS_LITLEN   = 4'd4,
        PS_SHORTOFF = 4'd5,
        PS_MLEN     = 4'd6,
        PS_OFFLO    = 4'd7,
        PS_OFFHI    = 4'd8
    } parse_state_t;

    typedef struct packed {
        logic       op;
        logic [7:0] packed_byte;
        logic       is_last;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic        copy_pending;
        logic [1:0]  status;
        logic [31:0] out_length;
    } out_item_t;

    // One decoded step handed from the parser to the write-back stage
    typedef struct packed {
        logic                 res_valid;
        logic                 is_drain;
        logic [ADDR_BITS-1:0] wr_addr;
        logic [ADDR_BITS-1:0] rd_addr;
        out_item_t            res;
    } step_t;

    function automatic logic [LENGTH_BITS-1:0] sat_add(
        input logic [LENGTH_BITS-1:0] a,
        input logic [9:0]             b
    );
        logic [LENGTH_BITS:0] s;
        s = {1'b0, a} + (LENGTH_BITS+1)'(b);
        return s[LENGTH_BITS] ? LEN_MAX : s[LENGTH_BITS-1:0];
    endfunction

endpackage

[sv/lzo_ram.sv]
`timescale 1ns / 1ps
// ============================================================================
// lzo_ram - generic single-write, single-read synchronous RAM
// Registered read, read-first on a same-address write.
// ============================================================================
module lzo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/lzo_parse.sv]
`timescale 1ns / 1ps
// ============================================================================
// lzo_parse - LZO1X instruction parser and stream counters
// Decodes one accepted transaction per cycle and forms the step for write-back.
// ============================================================================
module lzo_parse (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  lzo_pkg::in_item_t item,
    output lzo_pkg::step_t   step
);
    import lzo_pkg::*;

    parse_state_t            state_reg, state_next;
    logic [ADDR_BITS-1:0]    wp_reg, wp_next;
    logic [LENGTH_BITS-1:0]  pc_reg, pc_next;
    logic                    full_reg, full_next;
    logic [7:0]              held_reg, held_next;
    logic [LENGTH_BITS-1:0]  acc_reg, acc_next;
    logic [7:0]              offlo_reg, offlo_next;
    logic [LENGTH_BITS-1:0]  litl_reg, litl_next;
    logic [LENGTH_BITS-1:0]  copyl_reg, copyl_next;
    logic [15:0]             dist_reg, dist_next;
    logic                    after_reg, after_next;

    logic                    report, lit_ok, drain_ok, eof, bad;
    logic [1:0]              rstatus;
    logic                    match_go, begin_go, begin_long, copy_go;
    logic [LENGTH_BITS-1:0]  begin_n, copy_len;
    logic [DIST_BITS-1:0]    copy_d, m4_dist;
    logic [1:0]              copy_tr;
    logic [7:0]              b, t, code;
    logic [13:0]             off;
    logic [DIST_BITS-1:0]    d_mod;
    logic [ADDR_BITS-1:0]    rd_addr;
    logic [32:0]             pc_plus;

    assign b   = item.packed_byte;
    assign t   = held_reg;
    assign off = 14'({b, offlo_reg} >> 2);
    assign pc_plus = 33'(pc_reg) + 33'd1;

    // Fold the copy distance into the window and step back from the pointer
    always_comb
    begin
        d_mod = ({1'b0, dist_reg} >= DIST_BITS'(WINDOW_BYTES))
              ? {1'b0, dist_reg} - DIST_BITS'(WINDOW_BYTES) : {1'b0, dist_reg};
        if (DIST_BITS'(wp_reg) >= d_mod)
            rd_addr = ADDR_BITS'(DIST_BITS'(wp_reg) - d_mod);
        else
            rd_addr = ADDR_BITS'(DIST_BITS'(wp_reg) + DIST_BITS'(WINDOW_BYTES) - d_mod);
    end

    // Next-state logic
    always_comb
    begin
        state_next = state_reg;  wp_next = wp_reg;      pc_next = pc_reg;
        full_next  = full_reg;   held_next = held_reg;  acc_next = acc_reg;
        offlo_next = offlo_reg;  litl_next = litl_reg;  copyl_next = copyl_reg;
        dist_next  = dist_reg;   after_next = after_reg;
        report = 1'b0;  rstatus = ST_OK;  lit_ok = 1'b0;  drain_ok = 1'b0;
        eof = 1'b0;  bad = 1'b0;
        match_go = 1'b0;  begin_go = 1'b0;  begin_long = 1'b0;  copy_go = 1'b0;
        begin_n = '0;  copy_len = '0;  copy_d = '0;  copy_tr = 2'd0;
        code = 8'd0;  m4_dist = '0;

        if (accept)
        begin
            if (item.op == OP_DRAIN)
            begin
                if (copyl_reg != '0)
                begin
                    drain_ok   = 1'b1;
                    copyl_next = copyl_reg - LENGTH_BITS'(1);
                end
            end
            else if (copyl_reg != '0)
            begin
                report  = 1'b1;
                rstatus = ST_PENDING;
            end
            else
            begin
                case (state_reg)
                    PS_FIRST:
                    begin
                        if (b > FIRST_LIT_BIAS)
                        begin
                            begin_go   = 1'b1;
                            begin_n    = LENGTH_BITS'(b - FIRST_LIT_BIAS);
                            begin_long = (b - FIRST_LIT_BIAS) >= 8'd4;
                        end
                        else if (b >= 8'd16)
                            match_go = 1'b1;
                        else if (b == 8'd0)
                        begin
                            acc_next   = '0;
                            state_next = PS_LITLEN;
                        end
                        else
                        begin
                            begin_go = 1'b1;  begin_n = LENGTH_BITS'(b) + LENGTH_BITS'(3);
                            begin_long = 1'b1;
                        end
                    end
                    PS_MATCH:
                        match_go = 1'b1;
                    PS_LIT:
                    begin
                        lit_ok    = 1'b1;
                        litl_next = litl_reg - LENGTH_BITS'(1);
                        if (litl_reg == LENGTH_BITS'(1))
                            state_next = PS_MATCH;
                    end
                    PS_LITLEN:
                    begin
                        if (b == 8'd0)
                            acc_next = sat_add(acc_reg, ZERO_RUN_STEP);
                        else
                        begin
                            begin_go = 1'b1;  begin_long = 1'b1;
                            begin_n  = sat_add(acc_reg, 10'(b) + 10'd18);
                        end
                    end
                    PS_SHORTOFF:
                    begin
                        copy_go = 1'b1;
                        copy_tr = t[1:0];
                        if (t >= 8'd64)
                        begin
                            copy_d   = DIST_BITS'(1) + DIST_BITS'(t[4:2]) + (DIST_BITS'(b) << 3);
                            copy_len = LENGTH_BITS'(t[7:5]) + LENGTH_BITS'(1);
                        end
                        else if (after_reg)
                        begin
                            copy_d   = M2_FAR_BASE + DIST_BITS'(t[7:2]) + (DIST_BITS'(b) << 2);
                            copy_len = LENGTH_BITS'(3);
                        end
                        else
                        begin
                            copy_d   = DIST_BITS'(1) + DIST_BITS'(t[7:2]) + (DIST_BITS'(b) << 2);
                            copy_len = LENGTH_BITS'(2);
                        end
                    end
                    PS_MLEN:
                    begin
                        if (b == 8'd0)
                            acc_next = sat_add(acc_reg, ZERO_RUN_STEP);
                        else
                        begin
                            acc_next = sat_add(acc_reg, 10'(b) + 10'd2
                                       + 10'((t >= 8'd32) ? M3_BASE_LEN : M4_BASE_LEN));
                            state_next = PS_OFFLO;
                        end
                    end
                    PS_OFFLO:
                    begin
                        offlo_next = b;
                        state_next = PS_OFFHI;
                    end
                    PS_OFFHI:
                    begin
                        copy_tr  = offlo_reg[1:0];
                        copy_len = acc_reg;
                        if (t >= 8'd32)
                        begin
                            copy_go = 1'b1;
                            copy_d  = DIST_BITS'(1) + DIST_BITS'(off);
                        end
                        else
                        begin
                            m4_dist = (t[3] ? M4_BASE : '0) + DIST_BITS'(off);
                            if (m4_dist == '0)
                                eof = 1'b1;
                            else
                            begin
                                copy_go = 1'b1;
                                copy_d  = m4_dist + M4_BASE;
                            end
                        end
                    end
                    default:
                    begin
                        if (b >= 8'd16)
                            match_go = 1'b1;
                        else if (b == 8'd0)
                        begin
                            acc_next   = '0;
                            state_next = PS_LITLEN;
                        end
                        else
                        begin
                            begin_go = 1'b1;  begin_n = LENGTH_BITS'(b) + LENGTH_BITS'(3);
                            begin_long = 1'b1;
                        end
                    end
                endcase

                if (match_go)
                begin
                    held_next = b;
                    acc_next  = '0;
                    if (b >= 8'd64 || b < 8'd16)
                        state_next = PS_SHORTOFF;
                    else
                    begin
                        code = (b >= 8'd32) ? {3'd0, b[4:0]} : {5'd0, b[2:0]};
                        if (code == 8'd0)
                            state_next = PS_MLEN;
                        else
                        begin
                            acc_next   = LENGTH_BITS'(code) + LENGTH_BITS'(2);
                            state_next = PS_OFFLO;
                        end
                    end
                end

                if (copy_go)
                begin
                    if (!full_reg && 33'(copy_d) > 33'(pc_reg))
                        bad = 1'b1;
                    else
                    begin
                        dist_next  = copy_d[15:0];
                        copyl_next = copy_len;
                        if (copy_tr == 2'd0)
                            state_next = PS_INSTR;
                        else
                        begin
                            begin_go = 1'b1;  begin_n = LENGTH_BITS'(copy_tr);
                        end
                    end
                end

                if (begin_go)
                begin
                    litl_next  = begin_n;
                    after_next = begin_long;
                    state_next = (begin_n == '0) ? PS_MATCH : PS_LIT;
                end

                if (eof)
                begin
                    report  = 1'b1;
                    rstatus = item.is_last ? ST_OK : ST_LENGTH;
                end
                else if (bad)
                begin
                    report = 1'b1;  rstatus = ST_OFFSET;
                end
                else if (item.is_last)
                begin
                    report = 1'b1;  rstatus = ST_LENGTH;
                end
            end

            // Advance the window pointer and byte count for each byte emitted
            if ((drain_ok || lit_ok) && !report)
            begin
                wp_next   = (wp_reg == ADDR_BITS'(WINDOW_BYTES - 1)) ? '0
                          : wp_reg + ADDR_BITS'(1);
                pc_next   = pc_plus[LENGTH_BITS-1:0];
                full_next = full_reg || (pc_plus >= 33'(WINDOW_BYTES));
            end

            // Drop the whole stream context after a report
            if (report)
            begin
                state_next = PS_FIRST;  wp_next = '0;  pc_next = '0;  full_next = 1'b0;
                held_next = '0;  acc_next = '0;  offlo_next = '0;  litl_next = '0;
                copyl_next = '0;  dist_next = '0;  after_next = 1'b0;
            end
        end
    end

    // Output logic
    always_comb
    begin
        step.res_valid        = report || drain_ok || (lit_ok && !report);
        step.is_drain         = drain_ok;
        step.wr_addr          = wp_reg;
        step.rd_addr          = rd_addr;
        step.res.kind         = report ? KIND_REPORT : KIND_DATA;
        step.res.data_byte    = (lit_ok && !report) ? b : 8'd0;
        step.res.copy_pending = drain_ok && (copyl_reg != LENGTH_BITS'(1));
        step.res.status       = report ? rstatus : ST_OK;
        step.res.out_length   = (report && rstatus == ST_OK) ? 32'(pc_reg) : 32'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PS_FIRST;  wp_reg <= '0;  pc_reg <= '0;  full_reg <= 1'b0;
            held_reg <= '0;  acc_reg <= '0;  offlo_reg <= '0;  litl_reg <= '0;
            copyl_reg <= '0;  dist_reg <= '0;  after_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;  wp_reg <= wp_next;  pc_reg <= pc_next;
            full_reg <= full_next;  held_reg <= held_next;  acc_reg <= acc_next;
            offlo_reg <= offlo_next;  litl_reg <= litl_next;  copyl_reg <= copyl_next;
            dist_reg <= dist_next;  after_reg <= after_next;
        end
    end

endmodule

[sv/lzo1x_stream_decompressor.sv]
`timescale 1ns / 1ps
// ============================================================================
// lzo1x_stream_decompressor - LZO1X decoder, one byte per cycle unless stalled
// Parser, 64 KiB history RAM and a write-back stage with an output register.
// ============================================================================
// Feed compressed bytes (op 0) and drain ticks (op 1) on the byte channel;
// each accepted transaction yields at most one result transaction through
// the write-back and output registers, and a new transaction is taken every
// cycle while the result side keeps up. A drain tick reads the history RAM
// and write-back stores the fetched byte; a copy at distance one is served
// by forwarding the byte being written, so drains run back to back without
// bubbles. The stream ends with the M4 end marker flagged is_last, which
// returns an end report carrying the output length. Any report (ok or
// error) clears the stream context so the next byte starts a new stream.
// The history RAM is never cleared; distance checks keep reads inside bytes
// already written in the current stream.
module lzo1x_stream_decompressor (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_stall,
    input  lzo_pkg::in_item_t  byte_data,
    output logic               result_valid,
    input  logic               result_stall,
    output lzo_pkg::out_item_t result_data
);
    import lzo_pkg::*;

    logic       accept;
    step_t      step;
    step_t      s2_reg;
    logic       s2_valid_reg, s2_valid_next;
    logic       s2_move;
    logic       fwd_reg;
    logic [7:0] fwd_data_reg;
    logic [7:0] rdata;
    logic [7:0] s2_byte;
    logic       s2_writes;
    logic       out_valid_reg, out_valid_next;
    out_item_t  out_reg, out_next;

    // Hold the byte side only while write-back is full and the output is stuck
    assign s2_move    = s2_valid_reg && !(out_valid_reg && result_stall);
    assign byte_stall = s2_valid_reg && out_valid_reg && result_stall;
    assign accept     = byte_valid && !byte_stall;

    lzo_parse u_parse (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (byte_data),
        .step   (step)
    );

    lzo_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_BYTES)
    ) u_history (
        .clk   (clk),
        .we    (s2_writes && s2_move),
        .waddr (s2_reg.wr_addr),
        .wdata (s2_byte),
        .re    (accept),
        .raddr (step.rd_addr),
        .rdata (rdata)
    );

    // Pick the copy byte from the forward register or the RAM
    assign s2_byte   = s2_reg.is_drain ? (fwd_reg ? fwd_data_reg : rdata)
                                       : s2_reg.res.data_byte;
    assign s2_writes = s2_reg.res_valid && (s2_reg.res.kind == KIND_DATA);

    // Merge the fetched byte into the result transaction
    always_comb
    begin
        out_next           = s2_reg.res;
        out_next.data_byte = s2_writes ? s2_byte : 8'd0;
    end

    always_comb
    begin
        s2_valid_next = s2_valid_reg;
        if (accept)
            s2_valid_next = 1'b1;
        else if (s2_move)
            s2_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (s2_move)
            out_valid_next = s2_reg.res_valid;
        else if (out_valid_reg && !result_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_reg       <= 1'b0;
        end
        else
        begin
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
            // Forward the byte written this cycle when the new read hits it
            if (accept)
                fwd_reg <= s2_move && s2_writes && (s2_reg.wr_addr == step.rd_addr);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s2_reg       <= step;
            fwd_data_reg <= s2_byte;
        end
        if (s2_move)
        begin
            out_reg <= out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_reg;

endmodule

[sv/lzo_checker.sv]
`timescale 1ns / 1ps
// ============================================================================
// lzo_checker - port-level assertions for the decompressor
// Channel hold rules and report field consistency.
// ============================================================================
module lzo_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               byte_valid,
    input logic               byte_stall,
    input lzo_pkg::in_item_t  byte_data,
    input logic               result_valid,
    input logic               result_stall,
    input lzo_pkg::out_item_t result_data
);
    import lzo_pkg::*;

    a_byte_hold: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && byte_stall |=> byte_valid && $stable(byte_data))
        else $error("stalled byte changed");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result_data))
        else $error("stalled result changed");

    a_report_pending: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_data.kind == KIND_REPORT |-> !result_data.copy_pending)
        else $error("report with copy pending");

    a_data_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_data.kind == KIND_DATA
            |-> result_data.status == ST_OK && result_data.out_length == 32'd0)
        else $error("data byte with report fields");

    a_error_length: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_data.status != ST_OK |-> result_data.out_length == 32'd0)
        else $error("error report with length");

endmodule

bind lzo1x_stream_decompressor lzo_checker u_lzo_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_data    (byte_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
);
